### rtl/aaqt_pkg.sv
package aaqt_pkg;

    localparam int SAMPLE_W   = 14;
    localparam int ANGLE_W    = 11;
    localparam int PREV_W     = 12;
    localparam int TURN_W     = 16;
    localparam int BAND_W     = 8;
    localparam int DIVISOR_W  = 4;
    localparam int POS_W      = 32;
    localparam int NUM_W      = 28;
    localparam int DVD_W      = NUM_W + 1;
    localparam int DVS_W      = DIVISOR_W + 1;
    localparam int REM_W      = DVS_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam int MAX_TICKS_DEFAULT = 64;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS_BAND  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_DIVISOR = 1'b1;

    localparam logic [BAND_W-1:0]    HYSTERESIS_RESET = 8'd3;
    localparam logic [DIVISOR_W-1:0] DIVISOR_RESET    = 4'd10;

    // divide by ten: (x * 52429) >> 19 is exact for x below 2^15
    localparam logic [SAMPLE_W:0] ROUND_OFFSET = 15'd5;
    localparam logic [15:0]       RECIP_TEN    = 16'd52429;
    localparam int                RECIP_SHIFT  = 19;
    localparam int                RECIP_PROD_W = 31;

    localparam logic [ANGLE_W-1:0] WRAP_LOW  = 11'd100;
    localparam logic [ANGLE_W-1:0] WRAP_HIGH = 11'd1500;

    localparam logic signed [NUM_W-1:0] TURN_SCALE   = 28'sd1624;
    localparam logic signed [NUM_W-1:0] ANGLE_OFFSET = 28'sd1193;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    typedef struct packed {
        dir_t                dir;
        logic                set;
        logic [TURN_W-1:0]   turns;
        logic [ANGLE_W-1:0]  angle;
    } cmd_t;

endpackage

### rtl/aaqt_sample_if.sv
interface aaqt_sample_if;
    logic                            valid;
    logic                            ready;
    logic [aaqt_pkg::SAMPLE_W-1:0]   angle_sample;

    modport source (output valid, output angle_sample, input ready);
    modport sink   (input valid, input angle_sample, output ready);
endinterface

### rtl/aaqt_tick_if.sv
interface aaqt_tick_if;
    logic valid;
    logic ready;
    logic tick_direction;
    logic last_tick;

    modport source (output valid, output tick_direction, output last_tick, input ready);
    modport sink   (input valid, input tick_direction, input last_tick, output ready);
endinterface

### rtl/aaqt_front.sv
module aaqt_front (
    input  logic                            clk,
    input  logic                            rst_n,
    aaqt_sample_if.sink                     sample,
    input  logic [aaqt_pkg::BAND_W-1:0]     hysteresis_band,
    input  logic                            full,
    output logic                            push,
    output aaqt_pkg::cmd_t                  push_cmd
);

    logic [aaqt_pkg::PREV_W-1:0]       previous_angle_reg, previous_angle_next;
    logic [aaqt_pkg::TURN_W-1:0]       turn_count_reg, turn_count_next;
    aaqt_pkg::dir_t                    direction_reg, direction_next;

    logic [aaqt_pkg::SAMPLE_W:0]       rounded;
    logic [aaqt_pkg::RECIP_PROD_W-1:0] recip_prod;
    logic [aaqt_pkg::ANGLE_W-1:0]      scaled;
    logic [aaqt_pkg::PREV_W:0]         cur_w, band_w, old_w;
    logic [aaqt_pkg::PREV_W-1:0]       old_adj;
    logic                              accept, changed, move_cw, move_ccw, set;

    assign sample.ready = !full;
    assign accept       = sample.valid && sample.ready;

    assign rounded    = {1'b0, sample.angle_sample} + aaqt_pkg::ROUND_OFFSET;
    assign recip_prod = aaqt_pkg::RECIP_PROD_W'(rounded)
                      * aaqt_pkg::RECIP_PROD_W'(aaqt_pkg::RECIP_TEN);
    assign scaled     = recip_prod[aaqt_pkg::RECIP_SHIFT +: aaqt_pkg::ANGLE_W];
    assign changed    = aaqt_pkg::PREV_W'(scaled) != previous_angle_reg;

    assign cur_w  = (aaqt_pkg::PREV_W + 1)'(scaled);
    assign band_w = (aaqt_pkg::PREV_W + 1)'(hysteresis_band);

    always_comb
    begin
        old_adj         = previous_angle_reg;
        turn_count_next = turn_count_reg;
        // crossing the zero mark moves the reference next to the new angle
        if (scaled < aaqt_pkg::WRAP_LOW
            && previous_angle_reg > aaqt_pkg::PREV_W'(aaqt_pkg::WRAP_HIGH))
        begin
            old_adj         = aaqt_pkg::PREV_W'(cur_w + band_w);
            turn_count_next = turn_count_reg + aaqt_pkg::TURN_W'(1);
        end
        else if (scaled > aaqt_pkg::WRAP_HIGH
                 && previous_angle_reg < aaqt_pkg::PREV_W'(aaqt_pkg::WRAP_LOW))
        begin
            old_adj         = aaqt_pkg::PREV_W'(cur_w - band_w);
            turn_count_next = turn_count_reg - aaqt_pkg::TURN_W'(1);
        end
    end

    assign old_w    = (aaqt_pkg::PREV_W + 1)'(old_adj);
    assign move_cw  = cur_w > old_w + band_w;
    assign move_ccw = cur_w + band_w < old_w;
    assign set      = move_cw || move_ccw;

    always_comb
    begin
        if (move_cw)
            direction_next = aaqt_pkg::DIR_CW;
        else if (move_ccw)
            direction_next = aaqt_pkg::DIR_CCW;
        else
            direction_next = direction_reg;
    end

    assign previous_angle_next = set ? aaqt_pkg::PREV_W'(scaled) : old_adj;

    assign push           = accept && changed;
    assign push_cmd.dir   = direction_next;
    assign push_cmd.set   = set;
    assign push_cmd.turns = turn_count_next;
    assign push_cmd.angle = scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_angle_reg <= '0;
            turn_count_reg     <= '0;
            direction_reg      <= aaqt_pkg::DIR_NONE;
        end
        else if (push)
        begin
            previous_angle_reg <= previous_angle_next;
            turn_count_reg     <= turn_count_next;
            direction_reg      <= direction_next;
        end
    end

endmodule

### rtl/aaqt_queue.sv
module aaqt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  aaqt_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output aaqt_pkg::cmd_t pop_cmd,
    output logic           nonempty
);

    localparam int DEPTH = aaqt_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aaqt_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]  head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign nonempty = count_reg != '0;
    assign pop_cmd  = entry_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
        if (pop)
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[tail_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/aaqt_back.sv
module aaqt_back #(
    parameter int MAX_TICKS = aaqt_pkg::MAX_TICKS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    input  aaqt_pkg::cmd_t                   cmd,
    output logic                             pop,
    input  logic [aaqt_pkg::DIVISOR_W-1:0]   position_divisor,
    aaqt_tick_if.source                      tick
);

    localparam int CNT_W = $clog2(MAX_TICKS + 1);
    localparam int BIT_W = $clog2(aaqt_pkg::DVD_W + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TICK = 5'b00010,
        S_PREP = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t                                  state_reg, state_next;
    aaqt_pkg::cmd_t                          cmd_reg, cmd_next;
    logic signed [aaqt_pkg::NUM_W-1:0]       prod_reg, prod_next;
    logic [CNT_W-1:0]                        cnt_reg, cnt_next;
    logic                                    up_reg, up_next;
    logic signed [aaqt_pkg::POS_W-1:0]       target_reg, target_next;
    logic signed [aaqt_pkg::POS_W-1:0]       emitted_reg, emitted_next;
    logic                                    calib_reg, calib_next;
    logic                                    neg_reg, neg_next;
    logic [aaqt_pkg::DVD_W-1:0]              quo_reg, quo_next;
    logic [aaqt_pkg::REM_W-1:0]              rem_reg, rem_next;
    logic [aaqt_pkg::DVS_W-1:0]              dvs_reg, dvs_next;
    logic [BIT_W-1:0]                        bit_reg, bit_next;

    logic signed [aaqt_pkg::POS_W-1:0]       diff, quo_s;
    logic [aaqt_pkg::POS_W-1:0]              gap_abs;
    logic [CNT_W-1:0]                        steps;
    logic signed [aaqt_pkg::NUM_W-1:0]       turns_s, angle_s, num;
    logic [aaqt_pkg::NUM_W-1:0]              mag;
    logic [aaqt_pkg::DIVISOR_W-1:0]          div_eff;
    logic [aaqt_pkg::REM_W-1:0]              rem_sh;
    logic                                    tick_accept;

    assign tick.valid          = state_reg == S_TICK;
    assign tick.tick_direction = cmd_reg.dir == aaqt_pkg::DIR_CCW;
    assign tick.last_tick      = cnt_reg == CNT_W'(1);
    assign tick_accept         = tick.valid && tick.ready;

    assign diff    = target_reg - emitted_reg;
    assign gap_abs = diff[aaqt_pkg::POS_W-1] ? aaqt_pkg::POS_W'(-diff)
                                             : aaqt_pkg::POS_W'(diff);
    assign steps   = (cmd.dir == aaqt_pkg::DIR_NONE) ? '0
                   : (gap_abs > aaqt_pkg::POS_W'(MAX_TICKS)) ? CNT_W'(MAX_TICKS)
                   : CNT_W'(gap_abs);

    assign turns_s = aaqt_pkg::NUM_W'(signed'(cmd.turns));
    assign angle_s = signed'(aaqt_pkg::NUM_W'(cmd_reg.angle));
    assign num     = prod_reg + angle_s - aaqt_pkg::ANGLE_OFFSET;
    assign mag     = num[aaqt_pkg::NUM_W-1] ? aaqt_pkg::NUM_W'(-num)
                                            : aaqt_pkg::NUM_W'(num);
    assign div_eff = (position_divisor == '0) ? aaqt_pkg::DIVISOR_W'(1) : position_divisor;

    assign rem_sh = {rem_reg[aaqt_pkg::REM_W-2:0], quo_reg[aaqt_pkg::DVD_W-1]};
    assign quo_s  = signed'(aaqt_pkg::POS_W'(quo_reg));

    assign pop = (state_reg == S_IDLE) && cmd_valid;

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        prod_next    = prod_reg;
        cnt_next     = cnt_reg;
        up_next      = up_reg;
        target_next  = target_reg;
        emitted_next = emitted_reg;
        calib_next   = calib_reg;
        neg_next     = neg_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        bit_next     = bit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next  = cmd;
                    prod_next = turns_s * aaqt_pkg::TURN_SCALE;
                    cnt_next  = steps;
                    up_next   = target_reg > emitted_reg;
                    if (steps != '0)
                        state_next = S_TICK;
                    else if (cmd.set)
                        state_next = S_PREP;
                end
            end
            S_TICK:
            begin
                if (tick_accept)
                begin
                    emitted_next = up_reg ? emitted_reg + aaqt_pkg::POS_W'(1)
                                          : emitted_reg - aaqt_pkg::POS_W'(1);
                    cnt_next     = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                        state_next = cmd_reg.set ? S_PREP : S_IDLE;
                end
            end
            S_PREP:
            begin
                // (2|n| + d) / (2d) rounds half away from zero
                neg_next   = num[aaqt_pkg::NUM_W-1];
                quo_next   = {mag, 1'b0} + aaqt_pkg::DVD_W'(div_eff);
                dvs_next   = {div_eff, 1'b0};
                rem_next   = '0;
                bit_next   = BIT_W'(aaqt_pkg::DVD_W);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (rem_sh >= aaqt_pkg::REM_W'(dvs_reg))
                begin
                    rem_next = rem_sh - aaqt_pkg::REM_W'(dvs_reg);
                    quo_next = {quo_reg[aaqt_pkg::DVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[aaqt_pkg::DVD_W-2:0], 1'b0};
                end
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == BIT_W'(1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                target_next = neg_reg ? -quo_s : quo_s;
                // first target sets the count without ticking
                if (!calib_reg)
                begin
                    emitted_next = target_next;
                    calib_next   = 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        prod_reg <= prod_next;
        up_reg   <= up_next;
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            bit_reg     <= '0;
            target_reg  <= '0;
            emitted_reg <= '0;
            calib_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            bit_reg     <= bit_next;
            target_reg  <= target_next;
            emitted_reg <= emitted_next;
            calib_reg   <= calib_next;
        end
    end

`ifndef SYNTH
    a_tick_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        tick.valid |-> cnt_reg != '0)
        else $error("tick shown with empty count");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (tick.valid && tick.ready && tick.last_tick) |=> !tick.valid)
        else $error("tick follows the last tick of an item");

    a_calibrate_aligns: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(calib_reg) |-> emitted_reg == target_reg)
        else $error("calibration left count and target apart");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> dvs_reg != '0)
        else $error("divider running with zero divisor");
`endif

endmodule

### rtl/absolute_angle_to_quadrature_ticks.sv
// Turns 14-bit absolute angle samples into emulated quadrature ticks. Each sample is
// scaled to a tenth, checked for a wrap past zero and for motion beyond the hysteresis
// band, and queued as it is accepted; the input stalls only when the four-entry queue
// is full, and a sample whose scaled value is unchanged produces no ticks. The tick
// side takes a queued item whenever it is idle, emits up to MAX_TICKS ticks at one per
// cycle while tick.ready is high, and, when the sample set a direction, computes the new
// position target in a bit-serial divider (a setup step, 29 quotient bits, a finish step).
// The first target calibrates the tick count; ticks above MAX_TICKS stay pending for the
// next sample.
module absolute_angle_to_quadrature_ticks #(
    parameter int MAX_TICKS = aaqt_pkg::MAX_TICKS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    aaqt_sample_if.sink                       sample,
    aaqt_tick_if.source                       tick,
    input  logic                              cfg_we,
    input  logic [aaqt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aaqt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [aaqt_pkg::BAND_W-1:0]     hysteresis_reg, hysteresis_next;
    logic [aaqt_pkg::DIVISOR_W-1:0]  divisor_reg, divisor_next;

    logic            push, full, pop, nonempty;
    aaqt_pkg::cmd_t  push_cmd, pop_cmd;

    always_comb
    begin
        hysteresis_next = hysteresis_reg;
        divisor_next    = divisor_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                aaqt_pkg::CFG_HYSTERESIS_BAND:
                    hysteresis_next = cfg_data[aaqt_pkg::BAND_W-1:0];
                aaqt_pkg::CFG_POSITION_DIVISOR:
                    divisor_next = cfg_data[aaqt_pkg::DIVISOR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hysteresis_reg <= aaqt_pkg::HYSTERESIS_RESET;
            divisor_reg    <= aaqt_pkg::DIVISOR_RESET;
        end
        else
        begin
            hysteresis_reg <= hysteresis_next;
            divisor_reg    <= divisor_next;
        end
    end

    aaqt_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample          (sample),
        .hysteresis_band (hysteresis_reg),
        .full            (full),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    aaqt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .nonempty (nonempty)
    );

    aaqt_back #(
        .MAX_TICKS (MAX_TICKS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (nonempty),
        .cmd              (pop_cmd),
        .pop              (pop),
        .position_divisor (divisor_reg),
        .tick             (tick)
    );

endmodule

### tb/absolute_angle_to_quadrature_ticks_tb.sv
`timescale 1ns / 1ps

module absolute_angle_to_quadrature_ticks_tb;

    localparam int CLK_PERIOD        = 20;
    localparam int RESET_CYCLES      = 4;
    localparam int SETTLE_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT    = 3000;
    localparam int TICK_CAP          = aaqt_pkg::MAX_TICKS_DEFAULT;
    localparam int ANGLE_LOW         = 100;
    localparam int ANGLE_HIGH        = 1500;
    localparam int TURN_SPAN         = 1624;
    localparam int ZERO_OFFSET       = 1193;
    localparam int RAW_SPAN          = 16384;
    localparam int RANDOM_PHASES     = 6;
    localparam int SAMPLES_PER_PHASE = 27;
    localparam int STEADY_PHASE      = 3;
    localparam int DIRECTED_ROWS     = 25;

    localparam logic signed [7:0] PREDICTED = -8'sd1;
    localparam logic signed [7:0] NO_TICKS  = 8'sd0;

    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_BAND,
        ROW_DIVISOR
    } row_kind_t;

    typedef struct packed {
        row_kind_t                           kind;
        logic [aaqt_pkg::SAMPLE_W-1:0]       angle;
        logic [aaqt_pkg::CFG_DATA_W-1:0]     value;
        logic signed [7:0]                   ticks;
    } stim_row_t;

    typedef struct packed {
        logic ccw;
        logic last;
    } encoder_tick_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [aaqt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [aaqt_pkg::CFG_DATA_W-1:0] cfg_data;

    aaqt_sample_if sample_ch ();
    aaqt_tick_if   tick_ch ();

    absolute_angle_to_quadrature_ticks u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .tick      (tick_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // encoder state as the block should hold it
    logic [aaqt_pkg::BAND_W-1:0]    band;
    logic [aaqt_pkg::DIVISOR_W-1:0] divisor;
    int                             last_angle;
    logic [aaqt_pkg::TURN_W-1:0]    turns;
    aaqt_pkg::dir_t                 heading_dir;
    int                             goal_pos;
    int                             tick_pos;
    bit                             zeroed;

    encoder_tick_t ticks_due [$];
    encoder_tick_t due_tick;
    int            errors = 0;
    bit            steady = 1'b0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_SAMPLE,  14'd0,     8'h00, NO_TICKS},
        '{ROW_SAMPLE,  14'd4,     8'h00, NO_TICKS},   // still rounds to zero
        '{ROW_SAMPLE,  14'd5,     8'h00, NO_TICKS},   // rounds up, inside the band
        '{ROW_SAMPLE,  14'd16383, 8'h00, NO_TICKS},   // backward wrap, no direction yet
        '{ROW_SAMPLE,  14'd0,     8'h00, NO_TICKS},   // forward wrap, no direction yet
        '{ROW_SAMPLE,  14'd2000,  8'h00, NO_TICKS},   // first direction calibrates
        '{ROW_SAMPLE,  14'd3000,  8'h00, PREDICTED},
        '{ROW_SAMPLE,  14'd4000,  8'h00, PREDICTED},
        '{ROW_SAMPLE,  14'd3500,  8'h00, PREDICTED},
        '{ROW_SAMPLE,  14'd3510,  8'h00, PREDICTED},
        '{ROW_BAND,    14'd0,     8'h00, PREDICTED},
        '{ROW_SAMPLE,  14'd3520,  8'h00, PREDICTED},
        '{ROW_SAMPLE,  14'd3520,  8'h00, NO_TICKS},   // unchanged sample
        '{ROW_DIVISOR, 14'd0,     8'h01, PREDICTED},
        '{ROW_SAMPLE,  14'd16000, 8'h00, PREDICTED},
        '{ROW_SAMPLE,  14'd8000,  8'h00, PREDICTED},  // hits the tick cap
        '{ROW_SAMPLE,  14'd8000,  8'h00, NO_TICKS},   // cap overflow stays pending
        '{ROW_SAMPLE,  14'd8010,  8'h00, PREDICTED},
        '{ROW_BAND,    14'd0,     8'hFF, PREDICTED},
        '{ROW_SAMPLE,  14'd12000, 8'h00, PREDICTED},
        '{ROW_SAMPLE,  14'd12100, 8'h00, PREDICTED},
        '{ROW_DIVISOR, 14'd0,     8'hF0, PREDICTED},  // divisor zero acts as one
        '{ROW_SAMPLE,  14'd100,   8'h00, PREDICTED},
        '{ROW_DIVISOR, 14'd0,     8'hFF, PREDICTED},
        '{ROW_SAMPLE,  14'd16380, 8'h00, PREDICTED}
    };

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int emulate_encoder(input logic [aaqt_pkg::SAMPLE_W-1:0] raw,
                                           output logic ccw);
        int     cur;
        int     old;
        int     h;
        int     gap;
        int     n;
        bit     took;
        longint num;
        longint d;
        longint mag;
        longint q;
        cur  = (int'(raw) + 5) / 10;
        ccw  = 1'b0;
        n    = 0;
        took = 1'b0;
        if (cur == last_angle)
            return 0;
        old = last_angle;
        h   = int'(band);
        if (cur < ANGLE_LOW && old > ANGLE_HIGH)
        begin
            old   = cur + h;
            turns = turns + 1'b1;
        end
        if (cur > ANGLE_HIGH && old < ANGLE_LOW)
        begin
            old   = cur - h;
            turns = turns - 1'b1;
        end
        last_angle = old;
        if (cur - h > old)
        begin
            heading_dir = aaqt_pkg::DIR_CW;
            took        = 1'b1;
        end
        if (cur + h < old)
        begin
            heading_dir = aaqt_pkg::DIR_CCW;
            took        = 1'b1;
        end
        // step toward the old goal before taking the new one
        if (heading_dir != aaqt_pkg::DIR_NONE)
        begin
            gap = goal_pos - tick_pos;
            n   = (gap < 0) ? -gap : gap;
            if (n > TICK_CAP)
                n = TICK_CAP;
            tick_pos = (gap < 0) ? tick_pos - n : tick_pos + n;
            ccw      = (heading_dir == aaqt_pkg::DIR_CCW);
        end
        if (took)
        begin
            num = longint'($signed(turns)) * TURN_SPAN + cur - ZERO_OFFSET;
            d   = (divisor == '0) ? 64'sd1 : longint'(divisor);
            mag = (num < 0) ? -num : num;
            q   = (2 * mag + d) / (2 * d);
            goal_pos = int'((num < 0) ? -q : q);
            if (!zeroed)
            begin
                tick_pos = goal_pos;
                zeroed   = 1'b1;
            end
            last_angle = cur;
        end
        return n;
    endfunction

    task automatic send_sample(input logic [aaqt_pkg::SAMPLE_W-1:0] angle,
                               input int typed_ticks);
        int   n;
        int   i;
        logic ccw;
        while (!steady && $urandom_range(99) < 10)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.angle_sample <= angle;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        n = emulate_encoder(angle, ccw);
        if (typed_ticks >= 0)
            n = typed_ticks;
        for (i = 0; i < n; i++)
            ticks_due.push_back(encoder_tick_t'({ccw, i == n - 1}));
    endtask

    task automatic write_reg(input logic [aaqt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [aaqt_pkg::CFG_DATA_W-1:0] value);
        sample_ch.valid <= 1'b0;
        // let the divider finish on items that produced no ticks
        while (ticks_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == aaqt_pkg::CFG_HYSTERESIS_BAND)
            band = value;
        else
            divisor = value[aaqt_pkg::DIVISOR_W-1:0];
    endtask

    always @(posedge clk)
        tick_ch.ready <= steady || ($urandom_range(99) >= 10);

    always @(posedge clk)
    begin
        if (rst_n && tick_ch.valid && tick_ch.ready)
        begin
            if (ticks_due.size() == 0)
            begin
                errors++;
                $display("%0t: tick with none due: expected none, actual dir %0b last %0b",
                         $time, tick_ch.tick_direction, tick_ch.last_tick);
            end
            else
            begin
                due_tick = ticks_due.pop_front();
                if (tick_ch.tick_direction !== due_tick.ccw)
                begin
                    errors++;
                    $display("%0t: tick_direction expected %0b actual %0b",
                             $time, due_tick.ccw, tick_ch.tick_direction);
                end
                if (tick_ch.last_tick !== due_tick.last)
                begin
                    errors++;
                    $display("%0t: last_tick expected %0b actual %0b",
                             $time, due_tick.last, tick_ch.last_tick);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (tick_ch.valid && tick_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("absolute_angle_to_quadrature_ticks regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int                              r;
        int                              phase;
        int                              k;
        int                              pick;
        int                              stride;
        int                              heading;
        int                              shaft_raw;
        int                              div_pick;
        logic [aaqt_pkg::CFG_DATA_W-1:0] band_pick;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.angle_sample = '0;
        band        = aaqt_pkg::HYSTERESIS_RESET;
        divisor     = aaqt_pkg::DIVISOR_RESET;
        last_angle  = 0;
        turns       = '0;
        heading_dir = aaqt_pkg::DIR_NONE;
        goal_pos    = 0;
        tick_pos    = 0;
        zeroed      = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            case (directed_rows[r].kind)
                ROW_SAMPLE: send_sample(directed_rows[r].angle, directed_rows[r].ticks);
                ROW_BAND:   write_reg(aaqt_pkg::CFG_HYSTERESIS_BAND, directed_rows[r].value);
                default:    write_reg(aaqt_pkg::CFG_POSITION_DIVISOR, directed_rows[r].value);
            endcase
        end

        shaft_raw = 16380;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            steady    = 1'b0;
            band_pick = (phase == 0) ? 8'd0 : (phase == 1) ? 8'd255 : 8'($urandom_range(40));
            div_pick  = (phase == 0) ? 15 : (phase == 1) ? 1 : $urandom_range(15);
            write_reg(aaqt_pkg::CFG_HYSTERESIS_BAND, band_pick);
            write_reg(aaqt_pkg::CFG_POSITION_DIVISOR, {4'($urandom), 4'(div_pick)});
            steady  = (phase == STEADY_PHASE);
            heading = $urandom_range(1) ? 1 : -1;
            for (k = 0; k < SAMPLES_PER_PHASE; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                begin
                    // hold the angle
                end
                else if (pick < 16)
                begin
                    shaft_raw = $urandom_range(RAW_SPAN - 1);
                end
                else
                begin
                    stride = (pick < 26) ? $urandom_range(60) : $urandom_range(4000, 100);
                    if ($urandom_range(3) == 0)
                        stride = -stride;
                    shaft_raw = (shaft_raw + heading * stride + RAW_SPAN) % RAW_SPAN;
                end
                send_sample(shaft_raw[aaqt_pkg::SAMPLE_W-1:0], PREDICTED);
            end
        end

        steady = 1'b0;
        sample_ch.valid <= 1'b0;
        while (ticks_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("absolute_angle_to_quadrature_ticks regression: pass");
        else
            $display("absolute_angle_to_quadrature_ticks regression: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/aaqt_pkg.sv
rtl/aaqt_sample_if.sv
rtl/aaqt_tick_if.sv
rtl/aaqt_front.sv
rtl/aaqt_queue.sv
rtl/aaqt_back.sv
rtl/absolute_angle_to_quadrature_ticks.sv
tb/absolute_angle_to_quadrature_ticks_tb.sv
